// ===== hw/rtl/hre_pkg.sv =====
// ----------------------------------------------------------------------------
// hre_pkg
// Shared types, codes and helpers of the hex record encoder.
// ----------------------------------------------------------------------------
package hre_pkg;

  localparam int unsigned StoreDepth = 32;
  localparam int unsigned StoreAw    = 5;

  localparam logic [7:0] ChColon   = 8'h3A;
  localparam logic [7:0] ChS       = 8'h53;
  localparam logic [7:0] ChOne     = 8'h31;
  localparam logic [7:0] ChSeven   = 8'h37;
  localparam logic [7:0] ChNewline = 8'h0A;

  typedef enum logic [1:0] {
    REQ_DATA  = 2'd0,
    REQ_ADDR  = 2'd1,
    REQ_START = 2'd2,
    REQ_CLOSE = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    REC_DATA  = 2'd0,
    REC_START = 2'd1,
    REC_END   = 2'd2
  } rec_e;

  typedef enum logic [1:0] {
    EMIT_PFX   = 2'd0,
    EMIT_DIGIT = 2'd1,
    EMIT_NL    = 2'd2
  } emit_e;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_DISPATCH = 3'd1,
    ST_PFX      = 3'd2,
    ST_BYTE     = 3'd3,
    ST_NL       = 3'd4
  } ctrl_state_e;

  typedef struct packed {
    logic  accept;
    logic  store_byte;
    logic  set_addr;
    logic  rec_start;
    rec_e  rec_kind;
    logic  emit;
    emit_e emit_sel;
  } cmd_t;

  typedef struct packed {
    req_e req;
    logic fmt;
    logic held_zero;
    logic flush_due;
    logic can_adv;
    logic pfx_last;
    logic seq_last;
    logic kind_data;
  } status_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] ext;
    ext = {4'h0, nib};
    return (nib < 4'd10) ? (8'h30 + ext) : (8'h37 + ext);
  endfunction

endpackage

// ===== hw/rtl/hre_in_if.sv =====
// ----------------------------------------------------------------------------
// hre_in_if
// Request channel: request type, data byte and address.
// ----------------------------------------------------------------------------
interface hre_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [7:0]  data_byte;
  logic [31:0] address;

  modport source (output valid, req_type, data_byte, address, input ready);
  modport sink (input valid, req_type, data_byte, address, output ready);
endinterface

// ===== hw/rtl/hre_out_if.sv =====
// ----------------------------------------------------------------------------
// hre_out_if
// Text channel: up to eight ASCII characters per transfer.
// ----------------------------------------------------------------------------
interface hre_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] text_chars;
  logic [3:0]  char_count;
  logic        last;

  modport source (output valid, text_chars, char_count, last, input ready);
  modport sink (input valid, text_chars, char_count, last, output ready);
endinterface

// ===== hw/rtl/hre_cfg_if.sv =====
// ----------------------------------------------------------------------------
// hre_cfg_if
// Configuration write channel for the record format register.
// ----------------------------------------------------------------------------
interface hre_cfg_if;
  logic valid;
  logic ready;
  logic record_format;

  modport source (output valid, record_format, input ready);
  modport sink (input valid, record_format, output ready);
endinterface

// ===== hw/rtl/hre_ctrl.sv =====
// ----------------------------------------------------------------------------
// hre_ctrl
// Controller: dispatches requests and sequences record lines.
// ----------------------------------------------------------------------------
module hre_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  hre_pkg::status_t status_i,
  output logic             in_ready_o,
  output hre_pkg::cmd_t    cmd_o
);

  hre_pkg::ctrl_state_e state_q, state_d;
  logic                 flushing_q, flushing_d;

  logic                 disp_rec;
  hre_pkg::rec_e        disp_kind;
  logic                 disp_store;
  logic                 disp_set_addr;

  // Once a flush starts it drains the whole line store.
  always_comb begin
    disp_rec      = 1'b0;
    disp_kind     = hre_pkg::REC_DATA;
    disp_store    = 1'b0;
    disp_set_addr = 1'b0;
    unique case (status_i.req)
      hre_pkg::REQ_DATA: begin
        if (!status_i.held_zero && (status_i.flush_due || flushing_q)) begin
          disp_rec = 1'b1;
        end else begin
          disp_store = 1'b1;
        end
      end
      hre_pkg::REQ_ADDR: begin
        if (status_i.held_zero) disp_set_addr = 1'b1;
        else disp_rec = 1'b1;
      end
      hre_pkg::REQ_START: begin
        disp_rec = 1'b1;
        if (status_i.held_zero) disp_kind = hre_pkg::REC_START;
      end
      hre_pkg::REQ_CLOSE: begin
        if (!status_i.held_zero) begin
          disp_rec = 1'b1;
        end else if (!status_i.fmt) begin
          disp_rec  = 1'b1;
          disp_kind = hre_pkg::REC_END;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hre_pkg::ST_IDLE: if (in_valid_i) state_d = hre_pkg::ST_DISPATCH;
      hre_pkg::ST_DISPATCH: state_d = disp_rec ? hre_pkg::ST_PFX : hre_pkg::ST_IDLE;
      hre_pkg::ST_PFX: begin
        if (status_i.can_adv && status_i.pfx_last) state_d = hre_pkg::ST_BYTE;
      end
      hre_pkg::ST_BYTE: begin
        if (status_i.can_adv && status_i.seq_last) state_d = hre_pkg::ST_NL;
      end
      hre_pkg::ST_NL: begin
        if (status_i.can_adv) begin
          state_d = status_i.kind_data ? hre_pkg::ST_DISPATCH : hre_pkg::ST_IDLE;
        end
      end
      default: state_d = hre_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    flushing_d = flushing_q;
    unique case (state_q)
      hre_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) flushing_d = 1'b0;
      end
      hre_pkg::ST_DISPATCH: begin
        cmd_o.rec_start  = disp_rec;
        cmd_o.rec_kind   = disp_kind;
        cmd_o.store_byte = disp_store;
        cmd_o.set_addr   = disp_set_addr;
        if (disp_rec) flushing_d = 1'b1;
      end
      hre_pkg::ST_PFX: begin
        cmd_o.emit     = status_i.can_adv;
        cmd_o.emit_sel = hre_pkg::EMIT_PFX;
      end
      hre_pkg::ST_BYTE: begin
        cmd_o.emit     = status_i.can_adv;
        cmd_o.emit_sel = hre_pkg::EMIT_DIGIT;
      end
      hre_pkg::ST_NL: begin
        cmd_o.emit     = status_i.can_adv;
        cmd_o.emit_sel = hre_pkg::EMIT_NL;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= hre_pkg::ST_IDLE;
      flushing_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      flushing_q <= flushing_d;
    end
  end

endmodule

// ===== hw/rtl/hre_dp.sv =====
// ----------------------------------------------------------------------------
// hre_dp
// Datapath: line store, address and count registers, character generator
// and chunk assembler with its output register.
// ----------------------------------------------------------------------------
module hre_dp #(
  parameter int unsigned HEX_LINE_BYTES  = 32,
  parameter int unsigned SREC_LINE_BYTES = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hre_pkg::cmd_t    cmd_i,
  output hre_pkg::status_t status_o,
  input  logic [1:0]       req_type_i,
  input  logic [7:0]       data_byte_i,
  input  logic [31:0]      address_i,
  input  logic             cfg_we_i,
  input  logic             cfg_format_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [63:0]      text_chars_o,
  output logic [3:0]       char_count_o,
  output logic             last_o
);

  localparam int unsigned HexLimInt = (HEX_LINE_BYTES < 1) ? 1 :
      ((HEX_LINE_BYTES > hre_pkg::StoreDepth) ? hre_pkg::StoreDepth : HEX_LINE_BYTES);
  localparam int unsigned SrecLimInt = (SREC_LINE_BYTES < 1) ? 1 :
      ((SREC_LINE_BYTES > hre_pkg::StoreDepth) ? hre_pkg::StoreDepth : SREC_LINE_BYTES);
  localparam logic [5:0] HexLim  = 6'(HexLimInt);
  localparam logic [5:0] SrecLim = 6'(SrecLimInt);

  logic                  fmt_q;
  hre_pkg::req_e         req_q;
  logic [7:0]            byte_q;
  logic [31:0]           saddr_q;
  logic [5:0]            held_q;
  logic [15:0]           addr_q;
  logic [5:0]            base_q;

  hre_pkg::rec_e         kind_q;
  logic [5:0]            k_q;
  logic [2:0]            hdr_n_q;
  logic [5:0]            body_n_q;
  logic [5:0]            pos_q, pos_d;
  logic                  nib_q;
  logic                  pfx_q;
  logic [7:0]            sum_q;

  logic [7:0]            store_mem [hre_pkg::StoreDepth];
  logic [7:0]            rdata_q;
  logic [5:0]            rd_sum;

  logic [63:0]           chunk_q;
  logic [3:0]            cnt_q;
  logic                  out_valid_q;
  logic [63:0]           out_data_q;
  logic [3:0]            out_count_q;
  logic                  out_last_q;

  logic [5:0]            lim;
  logic [5:0]            k_new;
  logic [5:0]            end_pos;
  logic [7:0]            cnt_byte;
  logic [7:0]            sum_fin;
  logic [5:0]            body_idx;
  logic [7:0]            hdr_byte;
  logic [7:0]            body_byte;
  logic [7:0]            cur_byte;
  logic [7:0]            pfx_char;
  logic [7:0]            ch;
  logic                  is_nl;
  logic                  line_last;
  logic [63:0]           chunk_new;
  logic [3:0]            cnt_new;
  logic                  can_adv;
  logic                  rec_done;

  assign lim      = fmt_q ? SrecLim : HexLim;
  assign k_new    = (held_q > lim) ? lim : held_q;
  assign end_pos  = {3'b000, hdr_n_q} + body_n_q;
  assign cnt_byte = fmt_q ? ({2'b00, k_q} + 8'd3) : {2'b00, k_q};
  assign sum_fin  = fmt_q ? ~sum_q : (~sum_q + 8'd1);
  assign body_idx = pos_q - {3'b000, hdr_n_q};
  assign can_adv  = !out_valid_q || out_ready_i;
  assign rec_done = cmd_i.emit && (cmd_i.emit_sel == hre_pkg::EMIT_NL);

  always_comb begin
    pos_d = pos_q;
    if (cmd_i.rec_start) begin
      pos_d = '0;
    end else if (cmd_i.emit && (cmd_i.emit_sel == hre_pkg::EMIT_DIGIT) && nib_q) begin
      pos_d = pos_q + 6'd1;
    end
  end

  // The read address is formed from the next position, so the registered
  // data matches the current position.
  assign rd_sum = base_q + pos_d - {3'b000, hdr_n_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_byte) store_mem[held_q[hre_pkg::StoreAw-1:0]] <= byte_q;
    rdata_q <= store_mem[rd_sum[hre_pkg::StoreAw-1:0]];
  end

  always_comb begin
    hdr_byte = 8'h00;
    unique case (kind_q)
      hre_pkg::REC_DATA: begin
        unique case (pos_q[1:0])
          2'd0: hdr_byte = cnt_byte;
          2'd1: hdr_byte = addr_q[15:8];
          2'd2: hdr_byte = addr_q[7:0];
          default: hdr_byte = 8'h00;
        endcase
      end
      hre_pkg::REC_START: begin
        if (fmt_q || (pos_q[1:0] == 2'd3)) hdr_byte = 8'h05;
        else if (pos_q[1:0] == 2'd0) hdr_byte = 8'h04;
      end
      default: hdr_byte = (pos_q[1:0] == 2'd3) ? 8'h01 : 8'h00;
    endcase
  end

  always_comb begin
    if (kind_q == hre_pkg::REC_DATA) begin
      body_byte = rdata_q;
    end else begin
      unique case (body_idx[1:0])
        2'd0: body_byte = saddr_q[31:24];
        2'd1: body_byte = saddr_q[23:16];
        2'd2: body_byte = saddr_q[15:8];
        default: body_byte = saddr_q[7:0];
      endcase
    end
  end

  always_comb begin
    if (pos_q < {3'b000, hdr_n_q}) cur_byte = hdr_byte;
    else if (pos_q < end_pos) cur_byte = body_byte;
    else cur_byte = sum_fin;
  end

  always_comb begin
    if (!fmt_q) pfx_char = hre_pkg::ChColon;
    else if (!pfx_q) pfx_char = hre_pkg::ChS;
    else pfx_char = (kind_q == hre_pkg::REC_DATA) ? hre_pkg::ChOne : hre_pkg::ChSeven;
  end

  always_comb begin
    is_nl = 1'b0;
    unique case (cmd_i.emit_sel)
      hre_pkg::EMIT_PFX: ch = pfx_char;
      hre_pkg::EMIT_DIGIT: ch = hre_pkg::hex_char(nib_q ? cur_byte[3:0] : cur_byte[7:4]);
      default: begin
        ch    = hre_pkg::ChNewline;
        is_nl = 1'b1;
      end
    endcase
  end

  // A line is the last of its request when no further record follows it.
  assign line_last = (kind_q != hre_pkg::REC_DATA) ||
                     ((held_q == k_q) && (req_q != hre_pkg::REQ_START) &&
                      !((req_q == hre_pkg::REQ_CLOSE) && !fmt_q));

  always_comb begin
    chunk_new = chunk_q;
    chunk_new[cnt_q[2:0]*8 +: 8] = ch;
    cnt_new = cnt_q + 4'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q       <= 1'b0;
      held_q      <= '0;
      addr_q      <= '0;
      base_q      <= '0;
      cnt_q       <= '0;
      chunk_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) fmt_q <= cfg_format_i;
      if (cmd_i.store_byte) held_q <= held_q + 6'd1;
      if (cmd_i.set_addr) addr_q <= saddr_q[15:0];
      if (rec_done && (kind_q == hre_pkg::REC_DATA)) begin
        held_q <= held_q - k_q;
        addr_q <= addr_q + {10'd0, k_q};
        base_q <= (held_q == k_q) ? 6'd0 : (base_q + k_q);
      end
      if (cmd_i.emit) begin
        if ((cnt_new == 4'd8) || is_nl) begin
          chunk_q     <= '0;
          cnt_q       <= '0;
          out_valid_q <= 1'b1;
        end else begin
          chunk_q <= chunk_new;
          cnt_q   <= cnt_new;
          if (out_ready_i) out_valid_q <= 1'b0;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q   <= hre_pkg::req_e'(req_type_i);
      byte_q  <= data_byte_i;
      saddr_q <= address_i;
    end
    if (cmd_i.rec_start) begin
      kind_q <= cmd_i.rec_kind;
      unique case (cmd_i.rec_kind)
        hre_pkg::REC_DATA: begin
          k_q      <= k_new;
          hdr_n_q  <= fmt_q ? 3'd3 : 3'd4;
          body_n_q <= k_new;
        end
        hre_pkg::REC_START: begin
          k_q      <= '0;
          hdr_n_q  <= fmt_q ? 3'd1 : 3'd4;
          body_n_q <= 6'd4;
        end
        default: begin
          k_q      <= '0;
          hdr_n_q  <= 3'd4;
          body_n_q <= 6'd0;
        end
      endcase
      nib_q <= 1'b0;
      pfx_q <= 1'b0;
      sum_q <= '0;
    end else if (cmd_i.emit) begin
      if (cmd_i.emit_sel == hre_pkg::EMIT_PFX) pfx_q <= 1'b1;
      if (cmd_i.emit_sel == hre_pkg::EMIT_DIGIT) begin
        nib_q <= !nib_q;
        if (nib_q && (pos_q != end_pos)) sum_q <= sum_q + cur_byte;
      end
    end
    pos_q <= pos_d;
    if (cmd_i.emit && ((cnt_new == 4'd8) || is_nl)) begin
      out_data_q  <= chunk_new;
      out_count_q <= cnt_new;
      out_last_q  <= is_nl && line_last;
    end
  end

  assign status_o.req       = req_q;
  assign status_o.fmt       = fmt_q;
  assign status_o.held_zero = (held_q == 6'd0);
  assign status_o.flush_due = (held_q >= lim);
  assign status_o.can_adv   = can_adv;
  assign status_o.pfx_last  = !fmt_q || pfx_q;
  assign status_o.seq_last  = (pos_q == end_pos) && nib_q;
  assign status_o.kind_data = (kind_q == hre_pkg::REC_DATA);

  assign out_valid_o  = out_valid_q;
  assign text_chars_o = out_data_q;
  assign char_count_o = out_count_q;
  assign last_o       = out_last_q;

endmodule

// ===== hw/rtl/hex_record_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// hex_record_encoder_unit
// Byte stream to Intel HEX or S-record text lines.
// ----------------------------------------------------------------------------
// A data request that finds the line store below its line length only stores
// its byte. A record is produced one character per cycle, while the output
// register can take it, by the line sequencer after a dispatch state: the
// prefix, the hex digits and a newline. Text leaves in transfers of up to
// eight characters, each line starting a new transfer; the sequencer stalls
// while the output register holds a transfer that waits to be taken. A new
// request is accepted once every line caused by the previous one is formed.
module hex_record_encoder_unit #(
  parameter int unsigned HEX_LINE_BYTES  = 32,
  parameter int unsigned SREC_LINE_BYTES = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  hre_in_if.sink    in_if,
  hre_out_if.source out_if,
  hre_cfg_if.sink   cfg_if
);

  hre_pkg::cmd_t    cmd;
  hre_pkg::status_t status;

  assign cfg_if.ready = 1'b1;

  hre_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .status_i   (status),
    .in_ready_o (in_if.ready),
    .cmd_o      (cmd)
  );

  hre_dp #(
    .HEX_LINE_BYTES  (HEX_LINE_BYTES),
    .SREC_LINE_BYTES (SREC_LINE_BYTES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .req_type_i   (in_if.req_type),
    .data_byte_i  (in_if.data_byte),
    .address_i    (in_if.address),
    .cfg_we_i     (cfg_if.valid),
    .cfg_format_i (cfg_if.record_format),
    .out_valid_o  (out_if.valid),
    .out_ready_i  (out_if.ready),
    .text_chars_o (out_if.text_chars),
    .char_count_o (out_if.char_count),
    .last_o       (out_if.last)
  );

  a_data_rec_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.rec_start && (cmd.rec_kind == hre_pkg::REC_DATA)) |-> !status.held_zero)
    else $error("data record started with an empty line store");

  a_store_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.store_byte |-> !status.flush_due)
    else $error("byte stored into a full line");

  a_emit_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> status.can_adv)
    else $error("character emitted while the output register is blocked");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> ((out_if.char_count != 4'd0) && (out_if.char_count <= 4'd8)))
    else $error("chunk character count out of range");

endmodule
